// ===== design/pcwrl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcwrl_pkg
// shared types and constants of the per-connection window rate limiter
// ----------------------------------------------------------------------------
package pcwrl_pkg;

    localparam int unsigned NUM_CONNECTIONS = 16;
    localparam int unsigned CONN_W          = 4;
    localparam int unsigned IDX_W           = (NUM_CONNECTIONS > 1) ? $clog2(NUM_CONNECTIONS) : 1;
    localparam int unsigned TIME_W          = 32;
    localparam int unsigned CNT_W           = 16;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned CFG_DATA_W      = 32;
    localparam int unsigned ENTRY_W         = TIME_W + 2 * CNT_W;

    localparam logic [CNT_W-1:0]  CNT_MAX           = '1;
    localparam logic [TIME_W-1:0] WINDOW_TICKS_RST  = 32'd60000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_MESSAGES   = 2'd0,
        CFG_MAX_AUTOMATION = 2'd1,
        CFG_WINDOW_TICKS   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REASON_ALLOWED    = 2'd0,
        REASON_MSG_LIMIT  = 2'd1,
        REASON_AUTO_LIMIT = 2'd2
    } t_reason;

    typedef struct packed {
        logic              has_connection;
        logic [CONN_W-1:0] conn_index;
        logic [TIME_W-1:0] now_ms;
        logic              count_message;
        logic              count_automation;
    } t_in_item;

    typedef struct packed {
        logic             allowed;
        logic [1:0]       reason;
        logic [CNT_W-1:0] message_count;
        logic [CNT_W-1:0] automation_count;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0]  max_messages;
        logic [CNT_W-1:0]  max_automation;
        logic [TIME_W-1:0] window_ticks;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] start_ms;
        logic [CNT_W-1:0]  msg_cnt;
        logic [CNT_W-1:0]  auto_cnt;
    } t_entry;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
    endfunction

endpackage
`default_nettype wire

// ===== design/pcwrl_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcwrl_ram
// simple dual-port ram, one write and one registered read port, read-first
// ----------------------------------------------------------------------------
module pcwrl_ram #(
    parameter int unsigned DATA_W = 64,
    parameter int unsigned ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/pcwrl_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcwrl_update
// window restart, counter update and limit checks for one connection record
// ----------------------------------------------------------------------------
module pcwrl_update (
    input  wire pcwrl_pkg::t_in_item  i_item,
    input  wire pcwrl_pkg::t_cfg      i_cfg,
    input  wire logic                 i_started,
    input  wire pcwrl_pkg::t_entry    i_entry,
    output logic                      o_we,
    output pcwrl_pkg::t_entry         o_entry,
    output pcwrl_pkg::t_out_item      o_result
);
    import pcwrl_pkg::*;

    logic              conn_ok;
    logic              limits_off;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] elapsed;
    logic              restart;
    logic [CNT_W-1:0]  msg_base;
    logic [CNT_W-1:0]  auto_base;
    logic [CNT_W-1:0]  msg_new;
    logic [CNT_W-1:0]  auto_new;
    logic              msg_over;
    logic              auto_over;

    always_comb begin
        conn_ok    = i_item.has_connection
                     && ({{(32-CONN_W){1'b0}}, i_item.conn_index} < 32'(NUM_CONNECTIONS));
        limits_off = (i_cfg.max_messages == '0) && (i_cfg.max_automation == '0);
        start      = i_started ? i_entry.start_ms : i_item.now_ms;
        elapsed    = i_item.now_ms - start;
        restart    = (elapsed >= i_cfg.window_ticks);
        msg_base   = restart ? '0 : i_entry.msg_cnt;
        auto_base  = restart ? '0 : i_entry.auto_cnt;
        msg_new    = i_item.count_message    ? sat_inc(msg_base)  : msg_base;
        auto_new   = i_item.count_automation ? sat_inc(auto_base) : auto_base;
        msg_over   = (i_cfg.max_messages != '0) && (msg_new > i_cfg.max_messages);
        auto_over  = i_item.count_automation && (i_cfg.max_automation != '0)
                     && (auto_new > i_cfg.max_automation);

        o_we             = conn_ok && !limits_off;
        o_entry.start_ms = restart ? i_item.now_ms : start;
        o_entry.msg_cnt  = msg_new;
        o_entry.auto_cnt = auto_new;

        o_result.allowed          = 1'b1;
        o_result.reason           = REASON_ALLOWED;
        o_result.message_count    = '0;
        o_result.automation_count = '0;
        if (conn_ok) begin
            if (limits_off) begin
                o_result.message_count    = i_entry.msg_cnt;
                o_result.automation_count = i_entry.auto_cnt;
            end else begin
                o_result.message_count    = msg_new;
                o_result.automation_count = auto_new;
                if (msg_over) begin
                    o_result.allowed = 1'b0;
                    o_result.reason  = REASON_MSG_LIMIT;
                end else if (auto_over) begin
                    o_result.allowed = 1'b0;
                    o_result.reason  = REASON_AUTO_LIMIT;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/per_connection_window_rate_limiter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// per_connection_window_rate_limiter
// fixed-window message and automation limits, with windows kept per connection
// ----------------------------------------------------------------------------
// input beats (valid/ready) carry one event each; every event gives exactly
// one output beat with the verdict and the connection's counters.
// an accepted beat reads its connection record from the registered-read ram;
// the update stage then updates the record, writes it back and loads the
// output register that holds the result beat.
// one event per cycle is sustained while results are taken; the record ram's
// read-modify-write is the loop that sets this, with the previous cycle's
// write forwarded when consecutive events hit the same connection.
// a stalled receiver holds the output register; one more event may wait in
// the update stage, after which input ready drops.
// reset clears the started flags (flip-flops, one per connection), so the
// records read as zero with no clearing pass; the limits reset to zero and
// the window length to 60000 ms. configuration goes through a plain write
// port, only while the block is idle: the user's rule, not enforced here.
// ----------------------------------------------------------------------------
module per_connection_window_rate_limiter (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire pcwrl_pkg::t_in_item                    i_in_item,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output pcwrl_pkg::t_out_item                        o_out_item,
    input  wire logic                                   i_cfg_we,
    input  wire logic [pcwrl_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [pcwrl_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);
    import pcwrl_pkg::*;

    t_cfg                 r_cfg;
    logic                 r_s1_valid;
    t_in_item             r_s1_item;
    logic [NUM_CONNECTIONS-1:0] r_started;
    logic                 r_fw_valid;
    logic [IDX_W-1:0]     r_fw_idx;
    t_entry               r_fw_entry;
    logic                 r_out_valid;
    t_out_item            r_out_item;

    logic                 in_acc;
    logic                 s1_adv;
    logic [IDX_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     s1_idx;
    logic [ENTRY_W-1:0]   rd_data;
    logic                 started;
    t_entry               entry;
    logic                 upd_we;
    logic                 wr_en;
    t_entry               upd_entry;
    t_out_item            upd_result;

    assign rd_idx = i_in_item.conn_index[IDX_W-1:0];
    assign s1_idx = r_s1_item.conn_index[IDX_W-1:0];
    assign s1_adv = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc = i_in_valid && o_in_ready;
    assign wr_en  = s1_adv && upd_we;

    pcwrl_ram #(
        .DATA_W (ENTRY_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (s1_idx),
        .i_wdata (upd_entry),
        .i_re    (in_acc),
        .i_raddr (rd_idx),
        .o_rdata (rd_data)
    );

    always_comb begin
        started = r_started[s1_idx];
        if (r_fw_valid && (r_fw_idx == s1_idx)) begin
            entry = r_fw_entry;
        end else if (started) begin
            entry = t_entry'(rd_data);
        end else begin
            entry = '0;
        end
    end

    pcwrl_update u_update (
        .i_item    (r_s1_item),
        .i_cfg     (r_cfg),
        .i_started (started),
        .i_entry   (entry),
        .o_we      (upd_we),
        .o_entry   (upd_entry),
        .o_result  (upd_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_messages   <= '0;
            r_cfg.max_automation <= '0;
            r_cfg.window_ticks   <= WINDOW_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_MESSAGES:   r_cfg.max_messages   <= i_cfg_wdata[CNT_W-1:0];
                CFG_MAX_AUTOMATION: r_cfg.max_automation <= i_cfg_wdata[CNT_W-1:0];
                CFG_WINDOW_TICKS:   r_cfg.window_ticks   <= i_cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // update stage, started flags, output valid and forwarding of the write that overlapped the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_started   <= '0;
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_fw_valid <= wr_en;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (wr_en) begin
                r_started[s1_idx] <= 1'b1;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item  <= i_in_item;
            r_fw_idx   <= s1_idx;
            r_fw_entry <= upd_entry;
        end
        if (s1_adv) begin
            r_out_item <= upd_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the per-connection window rate limiter
// ----------------------------------------------------------------------------
// a ledger class keeps its own per-connection window records and limits,
// works out the verdict of every accepted event beat and checks each result
// beat against the oldest verdict due. the stimulus opens with directed events
// that cover disabled limits, refusals, window restarts and timestamp wrap. a
// burst on one connection follows, then random phases with random limits and
// window lengths. both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pcwrl_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    bit        quiet;

    per_connection_window_rate_limiter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    class window_ledger;
        logic [CNT_W-1:0]  msg_limit;
        logic [CNT_W-1:0]  auto_limit;
        logic [TIME_W-1:0] window_len;
        bit                opened     [NUM_CONNECTIONS];
        logic [TIME_W-1:0] opened_at  [NUM_CONNECTIONS];
        logic [CNT_W-1:0]  msg_tally  [NUM_CONNECTIONS];
        logic [CNT_W-1:0]  auto_tally [NUM_CONNECTIONS];
        t_out_item         due_verdicts[$];
        int                mismatches;
        int                beats_seen;

        function new();
            msg_limit  = '0;
            auto_limit = '0;
            window_len = WINDOW_TICKS_RST;
            for (int k = 0; k < NUM_CONNECTIONS; k++) begin
                opened[k]     = 1'b0;
                opened_at[k]  = '0;
                msg_tally[k]  = '0;
                auto_tally[k] = '0;
            end
            mismatches = 0;
            beats_seen = 0;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
            return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MAX_MESSAGES:   msg_limit  = data[CNT_W-1:0];
                CFG_MAX_AUTOMATION: auto_limit = data[CNT_W-1:0];
                CFG_WINDOW_TICKS:   window_len = data[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_event(t_in_item ev);
            t_out_item         v;
            int unsigned       k;
            logic [TIME_W-1:0] elapsed;
            v                  = '0;
            v.allowed          = 1'b1;
            v.reason           = REASON_ALLOWED;
            k                  = 32'(ev.conn_index);
            if (ev.has_connection && k < NUM_CONNECTIONS) begin
                if (msg_limit == '0 && auto_limit == '0) begin
                    v.message_count    = msg_tally[k];
                    v.automation_count = auto_tally[k];
                end else begin
                    if (!opened[k]) begin
                        opened[k]    = 1'b1;
                        opened_at[k] = ev.now_ms;
                    end
                    elapsed = ev.now_ms - opened_at[k];
                    if (elapsed >= window_len) begin
                        opened_at[k]  = ev.now_ms;
                        msg_tally[k]  = '0;
                        auto_tally[k] = '0;
                    end
                    if (ev.count_message)
                        msg_tally[k] = bump(msg_tally[k]);
                    if (ev.count_automation)
                        auto_tally[k] = bump(auto_tally[k]);
                    v.message_count    = msg_tally[k];
                    v.automation_count = auto_tally[k];
                    if (msg_limit != '0 && msg_tally[k] > msg_limit) begin
                        v.allowed = 1'b0;
                        v.reason  = REASON_MSG_LIMIT;
                    end else if (ev.count_automation && auto_limit != '0 &&
                                 auto_tally[k] > auto_limit) begin
                        v.allowed = 1'b0;
                        v.reason  = REASON_AUTO_LIMIT;
                    end
                end
            end
            due_verdicts.push_back(v);
        endfunction

        function int pending();
            return due_verdicts.size();
        endfunction

        task report_mismatch(string what);
            if (mismatches < 50)
                $display("mismatch at result beat %0d: %s", beats_seen, what);
            mismatches++;
        endtask

        task check_verdict(t_out_item got);
            t_out_item want;
            beats_seen++;
            if (due_verdicts.size() == 0) begin
                report_mismatch($sformatf("result beat %h with nothing due", got));
                return;
            end
            want = due_verdicts.pop_front();
            if (got.allowed !== want.allowed)
                report_mismatch($sformatf("allowed %b, want %b", got.allowed, want.allowed));
            if (got.reason !== want.reason)
                report_mismatch($sformatf("reason %0d, want %0d", got.reason, want.reason));
            if (got.message_count !== want.message_count)
                report_mismatch($sformatf("message_count %0d, want %0d",
                                          got.message_count, want.message_count));
            if (got.automation_count !== want.automation_count)
                report_mismatch($sformatf("automation_count %0d, want %0d",
                                          got.automation_count, want.automation_count));
        endtask
    endclass

    window_ledger ledger = new();

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("per_connection_window_rate_limiter test failed");
        $finish;
    end

    // result side
    initial begin
        int stall;
        out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (out_valid !== 1'b1);
            ledger.check_verdict(out_item);
        end
    end

    function automatic t_in_item make_event(int has, int idx, logic [TIME_W-1:0] now,
                                            int m, int a);
        t_in_item ev;
        ev.has_connection   = has[0];
        ev.conn_index       = idx[CONN_W-1:0];
        ev.now_ms           = now;
        ev.count_message    = m[0];
        ev.count_automation = a[0];
        return ev;
    endfunction

    task automatic send_event(t_in_item ev);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= ev;
        do @(posedge i_clk); while (in_ready !== 1'b1);
        ledger.note_event(ev);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        ledger.set_reg(idx, data);
    endtask

    // 16-bit limits go out with random upper bits, which the block drops
    task automatic configure(logic [CNT_W-1:0] msg_lim, logic [CNT_W-1:0] auto_lim,
                             logic [TIME_W-1:0] win);
        logic [15:0] junk_a;
        logic [15:0] junk_b;
        junk_a = 16'($urandom);
        junk_b = 16'($urandom);
        write_reg(CFG_MAX_MESSAGES, {junk_a, msg_lim});
        write_reg(CFG_MAX_AUTOMATION, {junk_b, auto_lim});
        write_reg(CFG_WINDOW_TICKS, win);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CNT_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CNT_W'($urandom_range(1, 3));
            2, 3:    return CNT_W'($urandom_range(1, 8));
            4:       return '1;
            default: return CNT_W'($urandom);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_window();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return TIME_W'(1);
            2, 3:    return TIME_W'($urandom_range(2, 60));
            4:       return '1;
            default: return TIME_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [TIME_W-1:0] base;
        int                pick;
        i_rst_n   <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_we    <= 1'b0;
        cfg_idx   <= CFG_MAX_MESSAGES;
        cfg_wdata <= '0;
        quiet     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // limits off after reset: nothing counted
        send_event(make_event(1, 1, 32'd1000, 1, 1));
        send_event(make_event(0, 15, 32'hFFFF_FFFF, 1, 1));
        wait_drain();

        // refusals, stored-count check, restart across timestamp wrap
        configure(16'd2, 16'd1, 32'd100);
        send_event(make_event(1, 2, 32'hFFFF_FFC0, 1, 0));
        send_event(make_event(1, 2, 32'hFFFF_FFD0, 1, 1));
        send_event(make_event(1, 2, 32'hFFFF_FFE0, 0, 1));
        send_event(make_event(1, 2, 32'hFFFF_FFF0, 1, 0));
        send_event(make_event(1, 2, 32'h0000_0010, 0, 0));
        send_event(make_event(1, 2, 32'h0000_0024, 1, 0));
        send_event(make_event(0, 2, 32'h0000_0000, 1, 1));
        send_event(make_event(1, 15, 32'd0, 0, 1));
        send_event(make_event(1, 15, 32'd5, 0, 1));
        send_event(make_event(1, 15, 32'd6, 0, 0));
        wait_drain();

        // both limits off: records left as they are
        configure(16'd0, 16'd0, 32'd100);
        send_event(make_event(1, 2, 32'd5000, 1, 1));
        send_event(make_event(1, 15, 32'd5000, 1, 1));
        wait_drain();

        // zero window length restarts on every event
        configure(16'd1, 16'd0, 32'd0);
        send_event(make_event(1, 3, 32'd77, 1, 0));
        send_event(make_event(1, 3, 32'd77, 1, 0));
        send_event(make_event(1, 2, 32'h8000_0000, 1, 1));
        wait_drain();

        configure(16'd0, 16'hFFFF, 32'hFFFF_FFFF);
        send_event(make_event(1, 4, 32'd9, 0, 1));
        send_event(make_event(1, 4, 32'd10, 1, 1));
        wait_drain();

        // back-to-back burst on one connection in a single window
        quiet = 1'b1;
        configure(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        repeat (24)
            send_event(make_event(1, 5, 32'h1234_5678, 1, 1));
        wait_drain();
        quiet = 1'b0;

        configure(16'hFFFE, 16'hFFFE, 32'hFFFF_FFFF);
        send_event(make_event(1, 5, 32'h1234_5679, 0, 1));
        send_event(make_event(1, 5, 32'h1234_567A, 1, 1));
        wait_drain();

        for (int ph = 0; ph < 8; ph++) begin
            configure(pick_limit(), pick_limit(), pick_window());
            quiet = ($urandom_range(0, 3) == 0);
            base  = $urandom_range(0, 1) ? 32'($urandom) : 32'hFFFF_FF00;
            for (int n = 0; n < 45; n++) begin
                pick = $urandom_range(0, 9);
                base = base + $urandom_range(0, 12);
                send_event(make_event(int'(pick != 0),
                                      (pick < 8) ? $urandom_range(0, 3) : $urandom_range(0, 15),
                                      (pick == 9) ? 32'($urandom) : base,
                                      $urandom_range(0, 1), $urandom_range(0, 1)));
            end
            wait_drain();
            quiet = 1'b0;
        end

        repeat (10) @(posedge i_clk);
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("per_connection_window_rate_limiter test passed");
        end else begin
            $display("per_connection_window_rate_limiter test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
design/pcwrl_pkg.sv
design/pcwrl_ram.sv
design/pcwrl_update.sv
design/per_connection_window_rate_limiter.sv
tb/testbench.sv
